@@ design/swot_pkg.sv @@
// Shared constants and types for the shortest window over threshold block.
`timescale 1ns / 1ps

package swot_pkg;

    // Default depth of the pending start queue
    localparam int MAX_WINDOW_DEFAULT = 16;

    // Field widths
    localparam int SAMPLE_W    = 32;
    localparam int OFFSET_W    = 32;
    localparam int LEN_W       = 5;
    localparam int RUN_SUM_W   = 36;
    localparam int WL_W        = 5;
    localparam int THRESHOLD_W = 32;

    // Stream widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 80;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register select, taken from the word address bit
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_THRESHOLD     = 1'b1;

    localparam logic [WL_W-1:0] WL_RESET = 5'd4;

    // One result beat
    typedef struct packed {
        logic [OFFSET_W-1:0]         start_offset;
        logic [LEN_W-1:0]            run_length;
        logic signed [RUN_SUM_W-1:0] run_sum;
        logic                        final_result;
    } result_t;

endpackage

@@ design/shortest_window_over_threshold.sv @@
// Shortest window over threshold: per-start window search over a sample stream.
// A settled start's result beat is registered in the head register, or the skid slot.
// Throughput: one sample per cycle; after a window_length shrink or an end_of_run beat the
// input stalls while further pending starts drain (up to MAX_WINDOW-1), since the start
// queue pops one start per cycle; it also stalls while both output slots hold beats.
// Reset (synchronous, aresetn low): queue empty, offsets zero, window_length 4, threshold 0.
`timescale 1ns / 1ps

module shortest_window_over_threshold #(
    parameter int MAX_WINDOW = swot_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swot_pkg::PADDR_W-1:0]    paddr,
    input  logic [swot_pkg::PDATA_W-1:0]    pwdata,
    output logic [swot_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swot_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic                            s_tlast,   // end_of_run
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swot_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] start_offset, [36:32] run_length,
                                                       // [72:37] run_sum, [79:73] zero
    output logic                            m_tlast    // final_result
);
    import swot_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int ACC_W = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int CMP_W = (CNT_W > WL_W) ? CNT_W : WL_W;

    // Configuration registers
    logic [WL_W-1:0]               window_length_reg;
    logic signed [THRESHOLD_W-1:0] threshold_reg;

    // Pending start queue, oldest at index 0
    logic signed [ACC_W-1:0] cell_sum_reg   [MAX_WINDOW];
    logic [CNT_W-1:0]        cell_len_reg   [MAX_WINDOW];
    logic                    cell_found_reg [MAX_WINDOW];
    logic [CNT_W-1:0]        count_reg;
    logic [OFFSET_W-1:0]     head_offset_reg;
    logic                    drain_reg;
    logic                    flush_reg;

    // Output buffer: head register plus skid slot
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;

    // Combinational
    logic                    cfg_wr;
    logic [CMP_W-1:0]        wl_ext;
    logic [CNT_W-1:0]        w_eff;
    logic                    accept;
    logic                    drain_pop;
    logic signed [ACC_W-1:0] sample_ext;
    logic signed [ACC_W-1:0] th_ext;
    logic [CNT_W-1:0]        count_inc;

    logic signed [ACC_W-1:0] src_sum   [MAX_WINDOW];
    logic [CNT_W-1:0]        src_len   [MAX_WINDOW];
    logic                    src_found [MAX_WINDOW];
    logic signed [ACC_W-1:0] cell_sum_next   [MAX_WINDOW];
    logic [CNT_W-1:0]        cell_len_next   [MAX_WINDOW];
    logic                    cell_found_next [MAX_WINDOW];

    logic [CNT_W-1:0]    src_count;
    logic [CNT_W-1:0]    count_after;
    logic                pop;
    logic                flushing;
    logic                others_found;
    logic                done;
    logic                res_push;
    result_t             res;
    logic [CNT_W-1:0]    count_next;
    logic [OFFSET_W-1:0] head_offset_next;
    logic                drain_next;
    logic                flush_next;
    logic                out_take;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[PADDR_W-1])
            REG_WINDOW_LENGTH: prdata = PDATA_W'(window_length_reg);
            REG_THRESHOLD:     prdata = PDATA_W'(threshold_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WL_RESET;
            threshold_reg     <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[PADDR_W-1])
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[WL_W-1:0];
                REG_THRESHOLD:     threshold_reg     <= pwdata[THRESHOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window: zero acts as one, clamp to queue depth
    assign wl_ext = CMP_W'(window_length_reg);
    always_comb begin
        if (wl_ext == '0) begin
            w_eff = CNT_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(wl_ext);
        end
    end

    // Handshake: the queue has one pop port, the buffer needs a free slot
    assign s_tready  = !drain_reg && !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign drain_pop = drain_reg && !skid_valid_reg;

    assign sample_ext = ACC_W'($signed(s_tdata[SAMPLE_W-1:0]));
    assign th_ext     = ACC_W'(threshold_reg);
    assign count_inc  = count_reg + CNT_W'(1);

    // Open a start and add the sample in every live cell not yet found or full, in parallel
    always_comb begin
        logic signed [ACC_W-1:0] base_sum;
        logic [CNT_W-1:0]        base_len;
        logic                    base_found;
        logic signed [ACC_W-1:0] add_sum;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (CNT_W'(k) < count_reg) begin
                base_sum   = cell_sum_reg[k];
                base_len   = cell_len_reg[k];
                base_found = cell_found_reg[k];
            end else begin
                base_sum   = '0;
                base_len   = '0;
                base_found = 1'b0;
            end
            add_sum = base_sum + sample_ext;
            if (accept && CNT_W'(k) <= count_reg && !base_found && base_len < w_eff) begin
                src_sum[k]   = add_sum;
                src_len[k]   = base_len + CNT_W'(1);
                src_found[k] = add_sum > th_ext;
            end else if (accept) begin
                src_sum[k]   = base_sum;
                src_len[k]   = base_len;
                src_found[k] = base_found;
            end else begin
                src_sum[k]   = cell_sum_reg[k];
                src_len[k]   = cell_len_reg[k];
                src_found[k] = cell_found_reg[k];
            end
        end
    end

    // Pop control: one start leaves the queue per cycle at most
    assign src_count = accept ? count_inc : count_reg;
    assign pop       = accept ? (s_tlast || count_inc >= w_eff) : drain_pop;
    assign flushing  = accept ? s_tlast : flush_reg;
    assign count_after = pop ? (src_count - CNT_W'(1)) : src_count;
    assign done = flushing ? (count_after == '0) : (count_after < w_eff);

    // Any later start still in the queue that found a window
    always_comb begin
        others_found = 1'b0;
        for (int k = 1; k < MAX_WINDOW; k++) begin
            if (src_found[k] && CNT_W'(k) < src_count) begin
                others_found = 1'b1;
            end
        end
    end

    assign res_push = pop && src_found[0];
    always_comb begin
        res.start_offset = head_offset_reg;
        res.run_length   = LEN_W'(src_len[0]);
        res.run_sum      = RUN_SUM_W'(src_sum[0]);
        res.final_result = flushing && !others_found;
    end

    // Shift the queue down on a pop
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (!pop) begin
                cell_sum_next[k]   = src_sum[k];
                cell_len_next[k]   = src_len[k];
                cell_found_next[k] = src_found[k];
            end else if (k < MAX_WINDOW - 1) begin
                cell_sum_next[k]   = src_sum[k + 1];
                cell_len_next[k]   = src_len[k + 1];
                cell_found_next[k] = src_found[k + 1];
            end else begin
                cell_sum_next[k]   = '0;
                cell_len_next[k]   = '0;
                cell_found_next[k] = 1'b0;
            end
        end
    end

    // Queue control next state
    always_comb begin
        count_next       = count_reg;
        head_offset_next = head_offset_reg;
        drain_next       = drain_reg;
        flush_next       = flush_reg;
        if (accept || drain_pop) begin
            count_next = count_after;
            drain_next = !done;
            flush_next = flushing && !done;
            if (flushing && done) begin
                head_offset_next = '0;
            end else if (pop) begin
                head_offset_next = head_offset_reg + OFFSET_W'(1);
            end
        end
    end

    // Queue storage, no reset needed past the fill count
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            cell_sum_reg[k]   <= cell_sum_next[k];
            cell_len_reg[k]   <= cell_len_next[k];
            cell_found_reg[k] <= cell_found_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            head_offset_reg <= '0;
            drain_reg       <= 1'b0;
            flush_reg       <= 1'b0;
        end else begin
            count_reg       <= count_next;
            head_offset_reg <= head_offset_next;
            drain_reg       <= drain_next;
            flush_reg       <= flush_next;
        end
    end

    // Output buffer: skid slot only fills while the head beat is stalled
    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_push;
            end
        end else if (res_push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (res_push) begin
                out_res_reg <= res;
            end
        end else if (res_push) begin
            skid_res_reg <= res;
        end
    end

    // Result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_res_reg.run_sum, out_res_reg.run_length,
                                  out_res_reg.start_offset});
    assign m_tlast  = out_res_reg.final_result;

endmodule
